### rtl/battery_level_averager_defines.svh
// ----------------------------------------------------------------------------
// battery level averager assertion macros
// shared concurrent assertion forms for the averager rtl
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_AVERAGER_DEFINES_SVH
`define BATTERY_LEVEL_AVERAGER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BLA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define BLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bla_pkg.sv
// ----------------------------------------------------------------------------
// bla_pkg
// widths, constants, register indexes and sequencer states of the averager
// ----------------------------------------------------------------------------
package bla_pkg;

  localparam int MV_W        = 13;
  localparam int PCT_W       = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 2;

  localparam int AVG_DEPTH_DEF = 4;

  localparam logic [MV_W-1:0]  BATT_CAP_MV     = 13'd4500;
  localparam logic [MV_W-1:0]  FULL_LEVEL_RST  = 13'd4200;
  localparam logic [MV_W-1:0]  EMPTY_LEVEL_RST = 13'd3300;
  localparam logic [PCT_W-1:0] PCT_FULL        = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY       = 7'd0;

  // interpolation numerator (avg - empty) * 100 stays below 2^20
  localparam int PCT_NUM_W = 20;
  // divisor is either the entry count or full - empty
  localparam int DIV_DEN_W = 13;

  localparam logic [CFG_ADDR_W-1:0] REG_FULL_LEVEL  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_EMPTY_LEVEL = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_AVG,
    ST_PCT,
    ST_DIV_PCT,
    ST_OUT
  } state_t;

endpackage

### rtl/bla_ram.sv
// ----------------------------------------------------------------------------
// bla_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bla_ram #(
  parameter int WIDTH  = 13,
  parameter int DEPTH  = 4,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/bla_div.sv
// ----------------------------------------------------------------------------
// bla_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bla_div
  import bla_pkg::*;
#(
  parameter int NUM_W = 20,
  parameter int DEN_W = DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_sub = rem_sh - {1'b0, den_r};

    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;

    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(NUM_W);
      quo_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
    end else if (run_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/battery_level_averager.sv
// ----------------------------------------------------------------------------
// battery_level_averager
// moving-average battery gauge: clamps and doubles the pin voltage, keeps a
// ring of recent samples, averages the filled entries and maps to percent
// ----------------------------------------------------------------------------
//  channel | ports                                  | word
//  --------+----------------------------------------+---------------------------
//  input   | in_tvalid  in_tready  in_tdata[15:0]   | pin_voltage_mv
//  output  | out_tvalid out_tready out_tdata[23:0]  | average_mv, charge_percent
//  config  | cfg_we cfg_addr cfg_wdata[12:0]        | full / empty level
//
// per word the ring is summed one ram read per cycle, then the one-bit-per-
// cycle divider runs for the average and, unless the percent saturates,
// again for the percent. reset is synchronous, active low; ring contents
// are not cleared. a finished word waits in the output register while the
// next one is taken; the next one stalls until it drains.
// ----------------------------------------------------------------------------
`include "battery_level_averager_defines.svh"

module battery_level_averager
  import bla_pkg::*;
#(
  parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [12:0] pin_voltage_mv
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [12:0] average_mv, [19:13] charge_percent
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [MV_W-1:0]        cfg_wdata
);

  localparam int AW     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CW     = $clog2(AVG_DEPTH + 1);
  localparam int SW     = MV_W + CW;
  localparam int DIV_NW = (SW > PCT_NUM_W) ? SW : PCT_NUM_W;

  state_t state_r, state_nxt;

  logic [AW-1:0]    slot_r, slot_nxt;
  logic             full_r, full_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    rd_idx_r, rd_idx_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [SW-1:0]    sum_r, sum_nxt;
  logic [MV_W-1:0]  avg_r, avg_nxt;
  logic [PCT_W-1:0] pct_r, pct_nxt;
  logic [MV_W-1:0]  full_lvl_r, empty_lvl_r;
  logic             out_valid_r, out_valid_nxt;
  logic [MV_W-1:0]  out_avg_r;
  logic [PCT_W-1:0] out_pct_r;

  logic             in_acc;
  logic             out_free;
  logic             sum_done;
  logic [MV_W-1:0]  pin_mv;
  logic [MV_W-1:0]  dbl_mv;
  logic [MV_W-1:0]  batt_mv;
  logic [MV_W-1:0]  ram_rdata;
  logic             div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic             div_done;
  logic [DIV_NW-1:0] div_quo;
  logic [MV_W-1:0]  pct_diff;
  logic [MV_W-1:0]  lvl_span;
  logic [PCT_NUM_W-1:0] pct_num;
  logic             load_out;

  assign pin_mv   = in_tdata[MV_W-1:0];
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign sum_done = (rd_idx_r == cnt_r) && !rd_pend_r;

  // negative pin reads as zero, then undo the halving divider and cap
  always_comb begin
    dbl_mv  = {pin_mv[MV_W-2:0], 1'b0};
    batt_mv = dbl_mv;
    if (pin_mv[MV_W-1]) begin
      batt_mv = '0;
    end else if (dbl_mv > BATT_CAP_MV) begin
      batt_mv = BATT_CAP_MV;
    end
  end

  bla_ram #(
    .WIDTH (MV_W),
    .DEPTH (AVG_DEPTH),
    .ADDR_W(AW)
  ) u_ring (
    .clk  (clk),
    .we   (in_acc),
    .waddr(slot_r),
    .wdata(batt_mv),
    .raddr(rd_idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign pct_diff = avg_r - empty_lvl_r;
  assign lvl_span = full_lvl_r - empty_lvl_r;
  assign pct_num  = PCT_NUM_W'(pct_diff) * PCT_NUM_W'(PCT_FULL);

  bla_div #(
    .NUM_W(DIV_NW),
    .DEN_W(DIV_DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sum_done) begin
          state_nxt = ST_DIV_AVG;
        end
      end
      ST_DIV_AVG: begin
        if (div_done) begin
          state_nxt = ST_PCT;
        end
      end
      ST_PCT: begin
        if ((avg_r >= full_lvl_r) || (avg_r <= empty_lvl_r)) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_DIV_PCT;
        end
      end
      ST_DIV_PCT: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    div_num   = DIV_NW'(sum_r);
    div_den   = DIV_DEN_W'(cnt_r);
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_SUM: begin
        div_start = sum_done;
      end
      ST_PCT: begin
        div_num   = DIV_NW'(pct_num);
        div_den   = lvl_span;
        div_start = (avg_r < full_lvl_r) && (avg_r > empty_lvl_r);
      end
      ST_OUT: begin
        load_out = out_free;
      end
      ST_DIV_AVG: begin
        div_start = 1'b0;
      end
      ST_DIV_PCT: begin
        div_start = 1'b0;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    slot_nxt    = slot_r;
    full_nxt    = full_r;
    cnt_nxt     = cnt_r;
    rd_idx_nxt  = rd_idx_r;
    rd_pend_nxt = rd_pend_r;
    sum_nxt     = sum_r;
    avg_nxt     = avg_r;
    pct_nxt     = pct_r;

    if (in_acc) begin
      if (slot_r == AW'(AVG_DEPTH - 1)) begin
        slot_nxt = '0;
        full_nxt = 1'b1;
      end else begin
        slot_nxt = slot_r + AW'(1);
      end
      cnt_nxt     = (full_r || (slot_r == AW'(AVG_DEPTH - 1))) ?
                    CW'(AVG_DEPTH) : CW'(slot_r + AW'(1));
      rd_idx_nxt  = '0;
      rd_pend_nxt = 1'b0;
      sum_nxt     = '0;
    end

    if (state_r == ST_SUM) begin
      // read data arrives in the cycle after its address
      if (rd_pend_r) begin
        sum_nxt = sum_r + SW'(ram_rdata);
      end
      if (rd_idx_r != cnt_r) begin
        rd_idx_nxt  = rd_idx_r + CW'(1);
        rd_pend_nxt = 1'b1;
      end else begin
        rd_pend_nxt = 1'b0;
      end
    end

    if ((state_r == ST_DIV_AVG) && div_done) begin
      avg_nxt = div_quo[MV_W-1:0];
    end

    if (state_r == ST_PCT) begin
      pct_nxt = (avg_r >= full_lvl_r) ? PCT_FULL : PCT_EMPTY;
    end

    if ((state_r == ST_DIV_PCT) && div_done) begin
      pct_nxt = (div_quo > DIV_NW'(PCT_FULL)) ? PCT_FULL : div_quo[PCT_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      full_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      full_lvl_r  <= FULL_LEVEL_RST;
      empty_lvl_r <= EMPTY_LEVEL_RST;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      full_r      <= full_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_FULL_LEVEL:  full_lvl_r  <= cfg_wdata;
          REG_EMPTY_LEVEL: empty_lvl_r <= cfg_wdata;
          default:         full_lvl_r  <= full_lvl_r;
        endcase
      end
    end
    cnt_r    <= cnt_nxt;
    rd_idx_r <= rd_idx_nxt;
    sum_r    <= sum_nxt;
    avg_r    <= avg_nxt;
    pct_r    <= pct_nxt;
    if (load_out) begin
      out_avg_r <= avg_r;
      out_pct_r <= pct_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - MV_W - PCT_W){1'b0}}, out_pct_r, out_avg_r};

  `BLA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready,
    "sequencer still ready after taking a word")
  `BLA_ASSERT_NOW(a_div_done_expected, clk, rst_n, div_done,
    (state_r == ST_DIV_AVG) || (state_r == ST_DIV_PCT),
    "divider finished outside a divide step")
  `BLA_ASSERT_NOW(a_out_in_range, clk, rst_n, out_valid_r,
    (out_avg_r <= BATT_CAP_MV) && (out_pct_r <= PCT_FULL),
    "result word out of range")

endmodule

### tb/sv/battery_level_averager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_averager_tb
// self-checking bench for the moving-average battery gauge: a queue-fed
// driver sends pin readings with random gaps, a monitor applies random
// backpressure and compares every result word against an in-bench gauge
// model, and the full / empty thresholds are swept between idle phases
// ----------------------------------------------------------------------------
module battery_level_averager_tb;
  import bla_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_ITEMS  = 116;
  localparam int MAX_PIN      = 4095;

  // result word as it sits in out_tdata, average_mv in the low bits
  typedef struct packed {
    logic [PCT_W-1:0] charge_percent;
    logic [MV_W-1:0]  average_mv;
  } gauge_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [12:0] pin_voltage_mv
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // [12:0] average_mv, [19:13] charge_percent
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [MV_W-1:0]        cfg_wdata = '0;

  battery_level_averager u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pending pin readings and expected gauge words
  logic [MV_W-1:0] pin_q[$];
  gauge_t          gauge_q[$];

  // gauge model state
  logic [MV_W-1:0] full_mv  = FULL_LEVEL_RST;
  logic [MV_W-1:0] empty_mv = EMPTY_LEVEL_RST;
  logic [MV_W-1:0] ring_mv [AVG_DEPTH_DEF];
  int              next_slot = 0;
  bit              ring_wrapped = 1'b0;

  int cycle_cnt = 0;
  int mismatches = 0;
  int readings_sent = 0;
  int words_checked = 0;
  int settings_used = 1;
  int src_gap = 0;
  int src_calm = 0;
  int sink_stall = 0;
  int sink_calm = 0;

  task automatic report_mismatch(string msg);
    $display("error at cycle %0d: %s", cycle_cnt, msg);
    mismatches++;
  endtask

  // random wait length, with occasional stretches of no waiting at all
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 6);
  endfunction

  function automatic gauge_t predict_gauge(logic [MV_W-1:0] pin);
    int     mv;
    int     sum;
    int     count;
    int     avg;
    int     pct;
    gauge_t g;
    // negative readings clamp to zero, then undo the divider and cap
    mv = pin[MV_W-1] ? 0 : 2 * int'(pin);
    if (mv > int'(BATT_CAP_MV)) mv = int'(BATT_CAP_MV);
    ring_mv[next_slot] = MV_W'(mv);
    next_slot++;
    if (next_slot == AVG_DEPTH_DEF) begin
      next_slot = 0;
      ring_wrapped = 1'b1;
    end
    count = ring_wrapped ? AVG_DEPTH_DEF : next_slot;
    sum = 0;
    for (int i = 0; i < count; i++) sum += int'(ring_mv[i]);
    avg = sum / count;
    // full test wins when the thresholds cross
    if (avg >= int'(full_mv)) begin
      pct = int'(PCT_FULL);
    end else if (avg <= int'(empty_mv)) begin
      pct = int'(PCT_EMPTY);
    end else begin
      pct = ((avg - int'(empty_mv)) * int'(PCT_FULL)) / (int'(full_mv) - int'(empty_mv));
      if (pct > int'(PCT_FULL)) pct = int'(PCT_FULL);
    end
    g.average_mv     = MV_W'(avg);
    g.charge_percent = PCT_W'(pct);
    return g;
  endfunction

  // threshold mirror follows the write port
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_addr)
        REG_FULL_LEVEL: begin
          full_mv <= cfg_wdata;
        end
        REG_EMPTY_LEVEL: begin
          empty_mv <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // source: one pin reading per word
  always @(posedge clk) begin : source
    int gap;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      gauge_q.push_back(predict_gauge(in_tdata[MV_W-1:0]));
      readings_sent++;
      gap = draw_wait(src_calm);
      if (gap == 0 && pin_q.size() > 0) begin
        in_tdata <= {{(IN_TDATA_W-MV_W){1'b0}}, pin_q.pop_front()};
      end else begin
        in_tvalid <= 1'b0;
        src_gap = gap;
      end
    end else if (!in_tvalid) begin
      // the gap runs while the block can take a word, so it lands on its idle phases
      if (src_gap > 0) begin
        if (in_tready || gauge_q.size() == 0) src_gap--;
      end else if (pin_q.size() > 0) begin
        in_tdata  <= {{(IN_TDATA_W-MV_W){1'b0}}, pin_q.pop_front()};
        in_tvalid <= 1'b1;
      end
    end
  end

  // sink: compare each gauge word, then stall a random number of valid cycles
  always @(posedge clk) begin : sink
    gauge_t got;
    gauge_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = gauge_t'(out_tdata[MV_W+PCT_W-1:0]);
        if (gauge_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word, average_mv %0d charge_percent %0d",
                                    got.average_mv, got.charge_percent));
        end else begin
          want = gauge_q.pop_front();
          words_checked++;
          if (got.average_mv !== want.average_mv)
            report_mismatch($sformatf("average_mv expected %0d got %0d",
                                      want.average_mv, got.average_mv));
          if (got.charge_percent !== want.charge_percent)
            report_mismatch($sformatf("charge_percent expected %0d got %0d (average %0d)",
                                      want.charge_percent, got.charge_percent,
                                      want.average_mv));
        end
        sink_stall = draw_wait(sink_calm);
      end else if (out_tvalid && sink_stall > 0) begin
        sink_stall--;
      end
      out_tready <= (sink_stall == 0);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycle_cnt, gauge_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pin_q.size() != 0 || in_tvalid || gauge_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_thresholds(logic [MV_W-1:0] full_lvl, logic [MV_W-1:0] empty_lvl);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_FULL_LEVEL;
    cfg_wdata <= full_lvl;
    @(posedge clk);
    cfg_addr  <= REG_EMPTY_LEVEL;
    cfg_wdata <= empty_lvl;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // pin value whose doubled reading sits on a threshold, saturated to the field
  function automatic logic [MV_W-1:0] pin_near(int level, int jitter);
    int p;
    p = level / 2 + jitter;
    if (p < 0) p = 0;
    if (p > MAX_PIN) p = MAX_PIN;
    return MV_W'(p);
  endfunction

  task automatic queue_random(int n);
    int              kind;
    int              lvl;
    logic [MV_W-1:0] pin;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      lvl  = $urandom_range(0, 1) ? int'(full_mv) : int'(empty_mv);
      if (kind < 8) begin
        // a full ring of one value puts the average right on a threshold
        pin = pin_near(lvl, 0);
        repeat (AVG_DEPTH_DEF) pin_q.push_back(pin);
      end else begin
        if (kind < 50)      pin = MV_W'($urandom_range(1400, 2300));
        else if (kind < 64) pin = pin_near(lvl, int'($urandom_range(0, 6)) - 3);
        else if (kind < 76) pin = MV_W'($urandom_range(0, 8191));
        else if (kind < 86) pin = MV_W'($urandom_range(4096, 8191));
        else if (kind < 94) pin = MV_W'($urandom_range(2240, MAX_PIN));
        else                pin = MV_W'($urandom_range(0, 50));
        pin_q.push_back(pin);
      end
    end
  endtask

  initial begin
    logic [MV_W-1:0] full_tab  [10];
    logic [MV_W-1:0] empty_tab [10];
    full_tab  = '{13'd4500, 13'd0, 13'd8191, 13'd3000, 13'd3600,
                  13'd4500, 13'd1, 13'd8191, 13'd4501, 13'd4200};
    empty_tab = '{13'd0,    13'd0, 13'd8191, 13'd4000, 13'd3600,
                  13'd4499, 13'd0, 13'd0,    13'd4500, 13'd3300};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // partly filled ring first, then sign, cap and threshold corners
    pin_q = '{13'd1, 13'd4095, 13'd4096, 13'd8191, 13'd0, 13'd2250, 13'd2249, 13'd2251,
              13'd1650, 13'd1650, 13'd1650, 13'd1650, 13'd2100, 13'd2100, 13'd2100,
              13'd2100, 13'd1651, 13'd1651, 13'd1651, 13'd1651, 13'd2099, 13'd1800};
    queue_random(PHASE_ITEMS);
    wait_idle();

    for (int s = 0; s < 10; s++) begin
      set_thresholds(full_tab[s], empty_tab[s]);
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    repeat (2) begin
      set_thresholds(MV_W'($urandom_range(3500, 4500)), MV_W'($urandom_range(2500, 3600)));
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (gauge_q.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", gauge_q.size()));

    $display("sent %0d pin readings across %0d threshold settings", readings_sent,
             settings_used);
    $display("checked %0d gauge words, %0d errors", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
